/* design/fpa_pkg.sv */
// Shared opcode type and field widths for the Q24.8 fixed-point ALU.
// No dependencies; fpa_if, fpa_front and the top level use it.
`default_nettype none
package fpa_pkg;
  localparam int IO_BITS  = 32;
  localparam int CMD_BITS = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_INC      = 4'd6,
    CMD_DEC      = 4'd7,
    CMD_FROM_INT = 4'd8,
    CMD_TO_INT   = 4'd9
  } cmd_e;
endpackage
`default_nettype wire

/* design/fpa_if.sv */
// Request and response channel interfaces of the fixed-point ALU.
// Depends on fpa_pkg for the field widths.
`default_nettype none
interface fpa_req_if;
  logic                               valid;
  logic                               ready;
  logic [fpa_pkg::CMD_BITS-1:0]       cmd;
  logic signed [fpa_pkg::IO_BITS-1:0] operand_a;
  logic signed [fpa_pkg::IO_BITS-1:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [fpa_pkg::IO_BITS-1:0] result;
  logic                               less;
  logic                               equal;
  logic                               greater;
  logic                               overflow;
  logic                               div_by_zero;
  modport source (output valid, result, less, equal, greater, overflow, div_by_zero,
                  input ready);
  modport sink (input valid, result, less, equal, greater, overflow, div_by_zero,
                output ready);
endinterface
`default_nettype wire

/* design/fixed_point_alu_q24_8.sv */
// Top level of the pipelined signed fixed-point ALU.
// Depends on fpa_pkg, fpa_if, fpa_front and fpa_div_step.
`default_nettype none
// Usage: a request on req_i carries cmd, operand_a and operand_b and is taken
// at a clock edge where valid and ready are both high. Each request gives
// exactly one response on rsp_o with the result, the comparison flags of
// operand_a against operand_b, and the overflow and divide-by-zero flags.
// Every operation travels the same pipeline, so responses leave in request
// order. The pipeline is an input register, the decode and multiply stage,
// the product rounding stage, one stage per quotient bit of the restoring
// divider, and the output register. The divider's per-bit stages set its
// depth. Throughput is one request per cycle for every opcode while the
// receiver does not stall.
// When the receiver stalls with a response waiting, the whole pipeline holds,
// empty stages included, and req_i.ready drops; ready depends only on the
// output register being empty or being taken.
// An asynchronous reset clears every valid bit; data registers are not reset.
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QW = WORD_BITS + FRAC_BITS;
  localparam int IO = fpa_pkg::IO_BITS;

  typedef struct packed {
    logic [fpa_pkg::CMD_BITS-1:0] cmd;
    logic [W-1:0]                 res;
    logic                         ovf;
    logic                         dz;
    logic                         lt;
    logic                         eq;
    logic                         neg;
    logic [W:0]                   rem;
    logic [QW-1:0]                nq;
    logic [W-1:0]                 d;
  } div_t;

  // The pipeline moves as a whole whenever the output register can take data.
  logic adv;
  logic out_v_q;
  assign adv         = ~out_v_q | rsp_o.ready;
  assign req_i.ready = adv;

  // Input register.
  logic                         v0_q;
  logic [fpa_pkg::CMD_BITS-1:0] cmd0_q;
  logic [W-1:0]                 a0_q, b0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd0_q <= req_i.cmd;
      a0_q   <= W'(req_i.operand_a);
      b0_q   <= W'(req_i.operand_b);
    end
  end

  // Decode, simple operations and the raw product of the magnitudes.
  logic [W-1:0] f_res, f_ma, f_mb;
  logic         f_ovf, f_lt, f_eq, f_neg;

  fpa_front #(.WORD_BITS(W), .FRAC_BITS(F)) u_front (
    .cmd_i (cmd0_q),
    .a_i   (a0_q),
    .b_i   (b0_q),
    .res_o (f_res),
    .ovf_o (f_ovf),
    .lt_o  (f_lt),
    .eq_o  (f_eq),
    .neg_o (f_neg),
    .mb_o  (f_mb),
    .ma_o  (f_ma)
  );

  logic                         v1_q;
  logic [fpa_pkg::CMD_BITS-1:0] cmd1_q;
  logic [W-1:0]                 res1_q, ma1_q, mb1_q;
  logic                         ovf1_q, lt1_q, eq1_q, neg1_q;
  logic [2*W-1:0]               prod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q  <= cmd0_q;
      res1_q  <= f_res;
      ovf1_q  <= f_ovf;
      lt1_q   <= f_lt;
      eq1_q   <= f_eq;
      neg1_q  <= f_neg;
      ma1_q   <= f_ma;
      mb1_q   <= f_mb;
      prod1_q <= f_ma * f_mb;
    end
  end

  // Product rounding and saturation, and the start of the divider.
  logic [2*W:0] pr, pmag, plim;
  div_t         st2_d;

  always_comb begin
    pr    = {1'b0, prod1_q} + ((2*W+1)'(1) << (F-1));
    pmag  = pr >> F;
    plim  = ((2*W+1)'(1) << (W-1)) - (neg1_q ? (2*W+1)'(0) : (2*W+1)'(1));
    st2_d = '0;
    st2_d.cmd = cmd1_q;
    st2_d.res = res1_q;
    st2_d.ovf = ovf1_q;
    st2_d.lt  = lt1_q;
    st2_d.eq  = eq1_q;
    st2_d.neg = neg1_q;
    st2_d.nq  = {ma1_q, F'(0)};
    st2_d.d   = mb1_q;
    if (cmd1_q == fpa_pkg::CMD_MUL) begin
      if (pmag > plim) begin
        st2_d.ovf = 1'b1;
        st2_d.res = {neg1_q, {(W-1){~neg1_q}}};
      end else begin
        st2_d.res = neg1_q ? (~pmag[W-1:0] + W'(1)) : pmag[W-1:0];
      end
    end
    if (cmd1_q == fpa_pkg::CMD_DIV) begin
      // A zero divisor leaves the result at zero with only its own flag raised.
      st2_d.res = '0;
      st2_d.dz  = (mb1_q == '0);
    end
  end

  // Divider chain: stage zero holds the prepared item, each later stage one bit.
  logic [QW:0] dv_q;
  div_t        dd_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= st2_d;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    div_t step_d;

    fpa_div_step #(.WORD_BITS(W), .QUO_BITS(QW)) u_step (
      .rem_i (dd_q[k-1].rem),
      .nq_i  (dd_q[k-1].nq),
      .d_i   (dd_q[k-1].d),
      .rem_o (step_d.rem),
      .nq_o  (step_d.nq)
    );

    assign step_d.cmd = dd_q[k-1].cmd;
    assign step_d.res = dd_q[k-1].res;
    assign step_d.ovf = dd_q[k-1].ovf;
    assign step_d.dz  = dd_q[k-1].dz;
    assign step_d.lt  = dd_q[k-1].lt;
    assign step_d.eq  = dd_q[k-1].eq;
    assign step_d.neg = dd_q[k-1].neg;
    assign step_d.d   = dd_q[k-1].d;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[k] <= step_d;
      end
    end
  end

  // Quotient rounding (half away from zero on magnitudes) and saturation.
  div_t        fin;
  logic [W:0]  half_gap;
  logic [QW:0] q1, qlim;
  logic [W-1:0] res_d;
  logic        ovf_d;

  always_comb begin
    fin      = dd_q[QW];
    half_gap = {1'b0, fin.d} - fin.rem;
    q1       = {1'b0, fin.nq} + (QW+1)'(fin.rem >= half_gap);
    qlim     = ((QW+1)'(1) << (W-1)) - (fin.neg ? (QW+1)'(0) : (QW+1)'(1));
    res_d    = fin.res;
    ovf_d    = fin.ovf;
    if (fin.cmd == fpa_pkg::CMD_DIV && !fin.dz) begin
      if (q1 > qlim) begin
        ovf_d = 1'b1;
        res_d = {fin.neg, {(W-1){~fin.neg}}};
      end else begin
        res_d = fin.neg ? (~q1[W-1:0] + W'(1)) : q1[W-1:0];
      end
    end
  end

  // Output register.
  logic [W-1:0] res_q;
  logic         ovf_q, dz_q, lt_q, eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
      dz_q  <= fin.dz;
      lt_q  <= fin.lt;
      eq_q  <= fin.eq;
    end
  end

  // Results narrower than the port are zero-filled, wider ones truncated.
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.result      = IO'(res_q);
  assign rsp_o.less        = lt_q;
  assign rsp_o.equal       = eq_q;
  assign rsp_o.greater     = ~lt_q & ~eq_q;
  assign rsp_o.overflow    = ovf_q;
  assign rsp_o.div_by_zero = dz_q;

`ifndef ASSERT_OFF
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $onehot({rsp_o.less, rsp_o.equal, rsp_o.greater}))
    else $error("comparison flags not one-hot");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.div_by_zero) |-> (rsp_o.result == '0 && !rsp_o.overflow))
    else $error("divide by zero response not cleared");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while output stalled");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.ready && v1_q) |=> dv_q[0])
    else $error("item lost entering the divider");
`endif
endmodule
`default_nettype wire

/* design/fpa_front.sv */
// Operand decode, comparison, the simple operations and the operand magnitudes for the product.
// Depends on fpa_pkg for the opcode type.
`default_nettype none
module fpa_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire  [fpa_pkg::CMD_BITS-1:0] cmd_i,
  input  wire  [WORD_BITS-1:0]         a_i,
  input  wire  [WORD_BITS-1:0]         b_i,
  output logic [WORD_BITS-1:0]         res_o,
  output logic                         ovf_o,
  output logic                         lt_o,
  output logic                         eq_o,
  output logic                         neg_o,
  output logic [WORD_BITS-1:0]         mb_o,
  output logic [WORD_BITS-1:0]         ma_o
);
  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  logic [W:0]     sa, sb, s_sum, s_dif, s_inc, s_dec, s_sel;
  logic [W+F-1:0] sh;
  logic [W-1:0]   shr;
  logic           fits;

  always_comb begin
    sa    = {a_i[W-1], a_i};
    sb    = {b_i[W-1], b_i};
    s_sum = sa + sb;
    s_dif = sa - sb;
    s_inc = sa + (W+1)'(1);
    s_dec = sa - (W+1)'(1);
    lt_o  = $signed(a_i) < $signed(b_i);
    eq_o  = a_i == b_i;
    neg_o = a_i[W-1] ^ b_i[W-1];
    ma_o  = a_i[W-1] ? (~a_i + W'(1)) : a_i;
    mb_o  = b_i[W-1] ? (~b_i + W'(1)) : b_i;
    sh    = {{F{a_i[W-1]}}, a_i} << F;
    fits  = (&sh[W+F-1:W-1]) | ~(|sh[W+F-1:W-1]);
    shr   = W'($signed(a_i) >>> F);
    s_sel = s_sum;
    res_o = '0;
    ovf_o = 1'b0;
    case (fpa_pkg::cmd_e'(cmd_i))
      fpa_pkg::CMD_ADD: s_sel = s_sum;
      fpa_pkg::CMD_SUB: s_sel = s_dif;
      fpa_pkg::CMD_INC: s_sel = s_inc;
      fpa_pkg::CMD_DEC: s_sel = s_dec;
      default:          s_sel = s_sum;
    endcase
    case (fpa_pkg::cmd_e'(cmd_i))
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        // A sign bit that disagrees with the extra top bit means the sum left the word.
        ovf_o = s_sel[W] ^ s_sel[W-1];
        if (ovf_o) begin
          res_o = {s_sel[W], {(W-1){~s_sel[W]}}};
        end else begin
          res_o = s_sel[W-1:0];
        end
      end
      fpa_pkg::CMD_MIN: res_o = lt_o ? a_i : b_i;
      fpa_pkg::CMD_MAX: res_o = lt_o ? b_i : a_i;
      fpa_pkg::CMD_FROM_INT: begin
        ovf_o = ~fits;
        if (fits) begin
          res_o = sh[W-1:0];
        end else begin
          res_o = {a_i[W-1], {(W-1){~a_i[W-1]}}};
        end
      end
      fpa_pkg::CMD_TO_INT: res_o = shr;
      default: res_o = '0;
    endcase
  end
endmodule
`default_nettype wire

/* design/fpa_div_step.sv */
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// No dependencies.
`default_nettype none
module fpa_div_step #(
  parameter int WORD_BITS = 32,
  parameter int QUO_BITS  = 40
) (
  input  wire  [WORD_BITS:0]   rem_i,
  input  wire  [QUO_BITS-1:0]  nq_i,
  input  wire  [WORD_BITS-1:0] d_i,
  output logic [WORD_BITS:0]   rem_o,
  output logic [QUO_BITS-1:0]  nq_o
);
  logic [WORD_BITS:0] r2;
  logic               ge;

  always_comb begin
    // The remainder stays below the divisor, so its top bit is always clear.
    r2    = {rem_i[WORD_BITS-1:0], nq_i[QUO_BITS-1]};
    ge    = r2 >= {1'b0, d_i};
    rem_o = ge ? (r2 - {1'b0, d_i}) : r2;
    nq_o  = {nq_i[QUO_BITS-2:0], ge};
  end
endmodule
`default_nettype wire
